/* design/grs_pkg.sv */
package grs_pkg;

  // Sizing of the group store
  localparam int MAX_GROUP = 16;
  localparam int ADDR_W    = $clog2(MAX_GROUP);
  localparam int CNT_W     = $clog2(MAX_GROUP + 1);
  localparam int DATA_W    = 32;
  localparam int GSIZE_W   = 5;

  // Group size after reset
  localparam logic [GSIZE_W-1:0] GSIZE_RESET = GSIZE_W'(2);

  // Store access driven by the sequencer
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } grs_ram_ctl_t;

endpackage

/* design/grs_ram.sv */
module grs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; read data holds when idle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/grs_ctrl.sv */
module grs_ctrl
  import grs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // group size register write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [GSIZE_W-1:0] cfg_data,
  // input handshake
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               end_of_sequence,
  // output handshake and side flags
  output logic               out_valid,
  input  logic               out_ready,
  output logic               last_of_run,
  output logic               sequence_done,
  // store access
  output grs_ram_ctl_t       ram_ctl
);

  typedef enum logic {
    IDLE,
    DRAIN
  } state_t;

  state_t             state;
  logic [GSIZE_W-1:0] group_size;
  logic [CNT_W-1:0]   fill;
  logic [CNT_W-1:0]   run_len;
  logic [CNT_W-1:0]   idx;
  logic               rev;
  logic               eos_q;

  logic [CNT_W-1:0]   eff_size;
  logic [ADDR_W-1:0]  wr_slot;
  logic [CNT_W-1:0]   fill_new;
  logic               full_group;
  logic               accept;
  logic               issue;
  logic               is_last;
  logic [CNT_W-1:0]   rev_addr;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == IDLE);
  assign accept    = in_valid && in_ready;

  // Effective group size: zero acts as one, saturate at the store depth
  always_comb begin
    if (group_size == '0) begin
      eff_size = CNT_W'(1);
    end else if (CNT_W'(group_size) > CNT_W'(MAX_GROUP)) begin
      eff_size = CNT_W'(MAX_GROUP);
    end else begin
      eff_size = CNT_W'(group_size);
    end
  end

  // Slot for the incoming word, clamped to the last entry
  assign wr_slot    = (fill >= CNT_W'(MAX_GROUP)) ? ADDR_W'(MAX_GROUP - 1) : fill[ADDR_W-1:0];
  assign fill_new   = CNT_W'(wr_slot) + CNT_W'(1);
  assign full_group = (fill_new >= eff_size);

  // Drain: one read per cycle whenever the output register frees up
  assign issue    = (state == DRAIN) && (!out_valid || out_ready);
  assign is_last  = (idx == run_len - CNT_W'(1));
  assign rev_addr = run_len - CNT_W'(1) - idx;

  always_comb begin
    ram_ctl.wr_en   = accept;
    ram_ctl.wr_addr = wr_slot;
    ram_ctl.rd_en   = issue;
    ram_ctl.rd_addr = rev ? rev_addr[ADDR_W-1:0] : idx[ADDR_W-1:0];
  end

  // Sequencer state and registered output flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      fill       <= '0;
      group_size <= GSIZE_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        group_size <= cfg_data;
      end

      if (issue) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        IDLE: begin
          if (accept) begin
            if (full_group || end_of_sequence) begin
              state   <= DRAIN;
              fill    <= '0;
              idx     <= '0;
              run_len <= fill_new;
              rev     <= full_group;
              eos_q   <= end_of_sequence;
            end else begin
              fill <= fill_new;
            end
          end
        end
        DRAIN: begin
          if (issue) begin
            last_of_run   <= is_last;
            sequence_done <= is_last && eos_q;
            idx           <= idx + CNT_W'(1);
            if (is_last) begin
              state <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

/* design/group_reverse_stream.sv */
// group_reverse_stream: reverses a stream in groups of group_size words.
//
// Channels: input words (value, end_of_sequence) and output words
// (out_value, last_of_run, sequence_done) use valid/ready; a word moves
// on a clock edge with both high. The cfg channel writes group_size
// (reset value 2; 0 acts as 1, anything above 16 acts as 16) and is
// always ready; write it only while the block is idle.
//
// Words that only fill a group produce nothing. A word that completes a
// group, or ends the sequence, starts a run: the held words are read
// back from the group store, one read per cycle, reversed for a full
// group and in arrival order for a short tail group.
// The first word of a run is read once the sequencer has entered its
// drain state and comes from the store's read register, then one word
// per cycle. The store has one read port, so a group is written word by
// word and then drained word by word; the input is held off (in_ready
// low) while a run drains. A stalled receiver holds the output register
// and pauses the drain. Reset empties the group and restores group_size;
// the store is not cleared, only written entries are ever read.
module group_reverse_stream
  import grs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [GSIZE_W-1:0]       cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [DATA_W-1:0] value,
  input  logic                     end_of_sequence,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_value,
  output logic                     last_of_run,
  output logic                     sequence_done
);

  grs_ram_ctl_t      ram_ctl;
  logic [DATA_W-1:0] rd_data;

  // Sequencer: fill count, group size and drain order
  grs_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .end_of_sequence (end_of_sequence),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .last_of_run     (last_of_run),
    .sequence_done   (sequence_done),
    .ram_ctl         (ram_ctl)
  );

  // Group store; its read register is the output data register
  grs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_GROUP)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_ctl.wr_en),
    .wr_addr (ram_ctl.wr_addr),
    .wr_data (value),
    .rd_en   (ram_ctl.rd_en),
    .rd_addr (ram_ctl.rd_addr),
    .rd_data (rd_data)
  );

  assign out_value = signed'(rd_data);

endmodule

/* design/grs_checker.sv */
module grs_checker
  import grs_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     end_of_sequence,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_value,
  input logic                     last_of_run,
  input logic                     sequence_done
);

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value)
      && $stable(last_of_run) && $stable(sequence_done))
    else $error("output word changed while stalled");

  // Sequence end only on the closing word of a run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && sequence_done |-> last_of_run)
    else $error("sequence_done without last_of_run");

  // No input taken while a run still has words to come
  a_no_in_mid_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> !in_ready)
    else $error("input accepted in the middle of a run");

  // The final word of a sequence always starts a run
  a_eos_drains: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && end_of_sequence |=> !in_ready)
    else $error("end of sequence did not start a run");

endmodule

bind group_reverse_stream grs_checker u_grs_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .end_of_sequence (end_of_sequence),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_value       (out_value),
  .last_of_run     (last_of_run),
  .sequence_done   (sequence_done)
);

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import grs_pkg::*;

  // One word of a reordered run
  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     last;
    logic                     done;
  } run_word_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [GSIZE_W-1:0]       cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] value = '0;
  logic                     end_of_sequence = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_value;
  logic                     last_of_run;
  logic                     sequence_done;

  // Predictor state: group size register and the words of the open group
  logic [GSIZE_W-1:0]       size_reg;
  logic signed [DATA_W-1:0] held[MAX_GROUP];
  int                       held_count;
  run_word_t                pending_words[$];
  int                       err_count;
  bit                       idle_en;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  group_reverse_stream dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .value           (value),
    .end_of_sequence (end_of_sequence),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .last_of_run     (last_of_run),
    .sequence_done   (sequence_done)
  );

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    err_count++;
  endtask

  // Store one word; a full group comes back reversed, a short tail at the
  // end of a sequence comes back in arrival order
  task automatic predict_word(input logic signed [DATA_W-1:0] v, input logic eos);
    int        k;
    int        n;
    int        i;
    bit        reverse;
    run_word_t w;
    if (size_reg == 0) begin
      k = 1;
    end else if (size_reg > MAX_GROUP) begin
      k = MAX_GROUP;
    end else begin
      k = int'(size_reg);
    end
    if (held_count >= MAX_GROUP) begin
      held_count = MAX_GROUP - 1;
    end
    held[held_count] = v;
    held_count++;
    reverse = (held_count >= k);
    if (reverse || eos) begin
      n = held_count;
      for (i = 0; i < n; i++) begin
        w.val  = reverse ? held[n - 1 - i] : held[i];
        w.last = (i == n - 1);
        w.done = (i == n - 1) && eos;
        pending_words.push_back(w);
      end
      held_count = 0;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic signed [DATA_W-1:0] v, input logic eos);
    while (idle_en && $urandom_range(99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    value           <= v;
    end_of_sequence <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(v, eos);
    @(negedge clk);
  endtask

  // Block is idle once every expected word is out and the pipe has drained
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_group_size(input logic [GSIZE_W-1:0] sz);
    cfg_valid <= 1'b1;
    cfg_data  <= sz;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    size_reg = sz;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly random words, with the sign and magnitude extremes mixed in
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Reset size of 2: one full group reversed, then a one-word tail
  task automatic test_reset_size();
    send_word(32'sh7FFF_FFFF, 1'b0);
    send_word(32'sh8000_0000, 1'b0);
    send_word(-32'sd1, 1'b1);
  endtask

  // Size 0 acts as 1, and size 1: every word passes straight through
  task automatic test_pass_through();
    wait_idle();
    write_group_size('0);
    send_word(32'sd0, 1'b1);
    wait_idle();
    write_group_size(5'd1);
    send_word(32'sh5A5A_A5A5, 1'b0);
  endtask

  // Size 31 saturates to 16; the group closes on the final word
  task automatic test_max_group();
    int i;
    wait_idle();
    write_group_size(5'd31);
    for (i = 0; i < MAX_GROUP; i++) begin
      send_word(pick_value(), i == MAX_GROUP - 1);
    end
  endtask

  // Shrink the group size while words are held; next word flushes them all
  task automatic test_resize_mid_group();
    wait_idle();
    write_group_size(5'd6);
    send_word(32'sh1234_5678, 1'b0);
    send_word(32'shEDCB_A987, 1'b0);
    wait_idle();
    write_group_size(5'd1);
    send_word(32'sh0F0F_0F0F, 1'b0);
  endtask

  // Short tail at the end of a sequence keeps arrival order
  task automatic test_tail_order();
    wait_idle();
    write_group_size(5'd6);
    send_word(32'sh0000_0011, 1'b0);
    send_word(32'sh0000_0022, 1'b0);
    send_word(32'sh0000_0033, 1'b1);
  endtask

  // Phases of random sizes with random sequences; some sequences are cut
  // short so the next size change lands mid-group. Once a few words are
  // in, at least 40 words go with no idling on either side.
  task automatic test_random();
    int                 words;
    int                 calm;
    int                 nseq;
    int                 s;
    int                 len;
    int                 i;
    int                 k;
    bit                 truncate;
    logic [GSIZE_W-1:0] sz;
    words = 0;
    calm  = 0;
    while (words < 90 || calm < 40) begin
      wait_idle();
      case ($urandom_range(9))
        0:       sz = '0;
        1:       sz = 5'd16;
        2:       sz = GSIZE_W'($urandom_range(17, 31));
        default: sz = GSIZE_W'($urandom_range(1, 8));
      endcase
      write_group_size(sz);
      idle_en = (words < 20) || (calm >= 40);
      k = (sz == 0) ? 1 : ((sz > MAX_GROUP) ? MAX_GROUP : int'(sz));
      nseq = $urandom_range(1, 3);
      for (s = 0; s < nseq; s++) begin
        len = $urandom_range(1, 2 * k + 1);
        truncate = (s == nseq - 1) && ($urandom_range(3) == 0);
        for (i = 0; i < len; i++) begin
          // an occasional early end of sequence as noise
          send_word(pick_value(),
                    ((i == len - 1) && !truncate) || ($urandom_range(19) == 0));
        end
        words += len;
        if (!idle_en) begin
          calm += len;
        end
      end
    end
    idle_en = 1'b1;
  endtask

  // Receiver stalls at random except during the no-idle stretch
  always @(negedge clk) begin
    out_ready <= !idle_en || ($urandom_range(99) >= 28);
  end

  // Compare each output word with the oldest expectation
  always @(posedge clk) begin : out_check
    run_word_t exp_w;
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", out_value));
      end else begin
        exp_w = pending_words.pop_front();
        if (out_value !== exp_w.val)
          report_mismatch($sformatf("out_value %h, want %h", out_value, exp_w.val));
        if (last_of_run !== exp_w.last)
          report_mismatch($sformatf("last_of_run %b, want %b", last_of_run, exp_w.last));
        if (sequence_done !== exp_w.done)
          report_mismatch($sformatf("sequence_done %b, want %b", sequence_done, exp_w.done));
      end
    end
  end

  initial begin
    int i;
    idle_en    = 1'b1;
    held_count = 0;
    size_reg   = GSIZE_RESET;
    err_count  = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_size();
    test_pass_through();
    test_max_group();
    test_resize_mid_group();
    test_tail_order();
    test_random();

    // drain with a bound, then let any stray word show up
    in_valid <= 1'b0;
    for (i = 0; i < 5000 && pending_words.size() != 0; i++) @(posedge clk);
    if (pending_words.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", pending_words.size()));
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("group_reverse_stream verification clean");
    end else begin
      $display("group_reverse_stream verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("group_reverse_stream verification failed");
    $finish;
  end

endmodule
